/* hdl/rsh_pkg.sv */
// ----------------------------------------------------------------------------
// rsh_pkg - ray / sphere hit test shared definitions
// Field widths, internal word widths, payload and pipeline structs.
// ----------------------------------------------------------------------------
package rsh_pkg;

  // field formats
  localparam int COORD_WIDTH   = 32;
  localparam int DIR_FRAC_BITS = 15;
  localparam int DIR_WIDTH     = DIR_FRAC_BITS + 2;
  localparam int RADIUS_WIDTH  = COORD_WIDTH - 1;

  // center minus origin, per axis
  localparam int DIFF_W = COORD_WIDTH + 1;
  // products of the second stage
  localparam int WSQ_W  = 2 * DIFF_W;
  localparam int RSQ_W  = 2 * RADIUS_WIDTH;
  localparam int WV_W   = DIFF_W + DIR_WIDTH;
  localparam int VSQ_W  = 2 * DIR_WIDTH;
  // sums over the three axes
  localparam int SQ_W   = WSQ_W + 2;
  localparam int DOT_W  = WV_W + 2;
  localparam int K_W    = VSQ_W + 3;
  // magnitudes once the sign checks are done
  localparam int DMAG_W = SQ_W - 1;
  localparam int KMAG_W = 2 * DIR_FRAC_BITS + 2;
  localparam int TU_W   = DOT_W - 1;
  // split of the projection for its square
  localparam int TH_W   = (TU_W + 1) / 2;
  localparam int TT_W   = TU_W - TH_W;
  localparam int TSQ_W  = 2 * TU_W;
  // split of the squared projection for the product with k
  localparam int CH_W   = KMAG_W;
  localparam int N_CH   = (TSQ_W + CH_W - 1) / CH_W;
  localparam int PAD_W  = N_CH * CH_W;
  localparam int LHS_W  = PAD_W + KMAG_W;
  localparam int RHS_W  = DMAG_W + 4 * DIR_FRAC_BITS;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // pipeline depth, input register to output register
  localparam int N_STG  = 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIR_WIDTH-1:0]   dir_t;
  typedef logic        [RADIUS_WIDTH-1:0] rad_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [WSQ_W-1:0]       wsq_t;
  typedef logic        [RSQ_W-1:0]       rsq_t;
  typedef logic signed [WV_W-1:0]        wv_t;
  typedef logic signed [VSQ_W-1:0]       vsq_t;
  typedef logic signed [SQ_W-1:0]        sq_t;
  typedef logic signed [DOT_W-1:0]       dot_t;
  typedef logic signed [K_W-1:0]         k_t;
  typedef logic        [KMAG_W-1:0]      kmag_t;
  typedef logic        [DMAG_W-1:0]      dmag_t;
  typedef logic        [TSQ_W-1:0]       tsq_t;
  typedef logic        [PAD_W-1:0]       pad_t;
  typedef logic        [2*CH_W-1:0]      chprod_t;
  typedef logic        [LHS_W-1:0]       lhs_t;
  typedef logic        [CMP_W-1:0]       cmp_t;

  // 2 * D^2 with D = 2^DIR_FRAC_BITS
  localparam k_t K_TOP = k_t'(64'd1 << (2 * DIR_FRAC_BITS + 1));

  // one query word
  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    dir_t   dir_x;
    dir_t   dir_y;
    dir_t   dir_z;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    rad_t   radius;
  } query_t;

  // load enables of the front stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } front_en_t;

  // sums leaving the front stages
  typedef struct packed {
    sq_t  diff;  // |W|^2 - r^2
    dot_t dot;   // W . V
    k_t   k;     // 2 D^2 - |V|^2
  } front_t;

  // decision bits that ride along the back stages
  typedef struct packed {
    logic  enclosed;
    logic  cand;
    dmag_t dmag;
  } side_t;

endpackage

/* hdl/rsh_if.sv */
// ----------------------------------------------------------------------------
// rsh_if - ray / sphere hit test channels
// Valid/ready channels for the query words and the hit words.
// ----------------------------------------------------------------------------
interface rsh_query_if;
  logic              valid;
  logic              ready;
  rsh_pkg::coord_t   origin_x;
  rsh_pkg::coord_t   origin_y;
  rsh_pkg::coord_t   origin_z;
  rsh_pkg::dir_t     dir_x;
  rsh_pkg::dir_t     dir_y;
  rsh_pkg::dir_t     dir_z;
  rsh_pkg::coord_t   center_x;
  rsh_pkg::coord_t   center_y;
  rsh_pkg::coord_t   center_z;
  rsh_pkg::rad_t     radius;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, radius,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, radius,
    output ready
  );
endinterface

interface rsh_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

/* hdl/rsh_front.sv */
// ----------------------------------------------------------------------------
// rsh_front - front stages of the hit test
// Center minus origin, the squares and dot products, and their sums.
// ----------------------------------------------------------------------------
module rsh_front (
  input  logic               clk,
  input  rsh_pkg::front_en_t en,
  input  rsh_pkg::query_t    q,
  output rsh_pkg::front_t    f
);

  rsh_pkg::diff_t w_x, w_y, w_z;
  rsh_pkg::dir_t  v_x, v_y, v_z;
  rsh_pkg::rad_t  r;

  rsh_pkg::wsq_t  wsq_x, wsq_y, wsq_z;
  rsh_pkg::wv_t   wv_x, wv_y, wv_z;
  rsh_pkg::vsq_t  vsq_x, vsq_y, vsq_z;
  rsh_pkg::rsq_t  rsq;

  // stage 1: vector from origin to center
  always_ff @(posedge clk) begin
    if (en.s1) begin
      w_x <= rsh_pkg::diff_t'(q.center_x) - rsh_pkg::diff_t'(q.origin_x);
      w_y <= rsh_pkg::diff_t'(q.center_y) - rsh_pkg::diff_t'(q.origin_y);
      w_z <= rsh_pkg::diff_t'(q.center_z) - rsh_pkg::diff_t'(q.origin_z);
      v_x <= q.dir_x;
      v_y <= q.dir_y;
      v_z <= q.dir_z;
      r   <= q.radius;
    end
  end

  // stage 2: one multiply per term
  always_ff @(posedge clk) begin
    if (en.s2) begin
      wsq_x <= w_x * w_x;
      wsq_y <= w_y * w_y;
      wsq_z <= w_z * w_z;
      wv_x  <= rsh_pkg::wv_t'(w_x) * rsh_pkg::wv_t'(v_x);
      wv_y  <= rsh_pkg::wv_t'(w_y) * rsh_pkg::wv_t'(v_y);
      wv_z  <= rsh_pkg::wv_t'(w_z) * rsh_pkg::wv_t'(v_z);
      vsq_x <= rsh_pkg::vsq_t'(v_x) * rsh_pkg::vsq_t'(v_x);
      vsq_y <= rsh_pkg::vsq_t'(v_y) * rsh_pkg::vsq_t'(v_y);
      vsq_z <= rsh_pkg::vsq_t'(v_z) * rsh_pkg::vsq_t'(v_z);
      rsq   <= rsh_pkg::rsq_t'(r) * rsh_pkg::rsq_t'(r);
    end
  end

  // stage 3: sums over the axes
  always_ff @(posedge clk) begin
    if (en.s3) begin
      f.diff <= rsh_pkg::sq_t'(wsq_x) + rsh_pkg::sq_t'(wsq_y)
              + rsh_pkg::sq_t'(wsq_z) - rsh_pkg::sq_t'(rsq);
      f.dot  <= rsh_pkg::dot_t'(wv_x) + rsh_pkg::dot_t'(wv_y)
              + rsh_pkg::dot_t'(wv_z);
      f.k    <= rsh_pkg::K_TOP - rsh_pkg::k_t'(vsq_x) - rsh_pkg::k_t'(vsq_y)
              - rsh_pkg::k_t'(vsq_z);
    end
  end

endmodule

/* hdl/ray_sphere_hit_test_core.sv */
// ----------------------------------------------------------------------------
// ray_sphere_hit_test_core - exact ray / sphere hit test
// Eight-stage pipeline answering one ray / sphere query per word.
// ----------------------------------------------------------------------------
// The core takes one query word per clock while the result side does not
// stall, and returns one hit word per query, in order, from its output
// register. Every stage holds one multiply of at most 33 by 33 bits or one
// wide add or compare, so the squared projection and its product with the
// direction term are built from partial products over four stages. A stall
// on the result side holds only the stages that are full: empty stages still
// move, so query words keep being taken until all eight stages hold a word.
// With W = center - origin, t = W.V and D = 2^15, a hit is |W|^2 <= r^2, or
// t >= 0 and t^2 (2 D^2 - |V|^2) > D^4 (|W|^2 - r^2), which is the exact
// squared-distance test rewritten so that no wide vector square is formed.
module ray_sphere_hit_test_core (
  input logic        clk,
  input logic        rst,
  rsh_query_if.sink  query,
  rsh_hit_if.source  result
);

  // pipeline control
  logic [rsh_pkg::N_STG:1] vld;
  logic [rsh_pkg::N_STG:1] en;

  rsh_pkg::query_t    q;
  rsh_pkg::front_en_t fen;
  rsh_pkg::front_t    f;

  // stage 4 to 8 data
  logic [rsh_pkg::TU_W-1:0]           tu;
  logic [rsh_pkg::TT_W-1:0]           th;
  logic [rsh_pkg::TH_W-1:0]           tl;
  logic [2*rsh_pkg::TT_W-1:0]         hh;
  logic [rsh_pkg::TT_W+rsh_pkg::TH_W-1:0] hl;
  logic [2*rsh_pkg::TH_W-1:0]         ll;
  rsh_pkg::kmag_t                     kmag4, kmag5;
  rsh_pkg::side_t                     side_c, s4, s5, s6, s7;
  rsh_pkg::tsq_t                      tsq;
  rsh_pkg::pad_t                      tsq_pad;
  rsh_pkg::chprod_t                   prod [rsh_pkg::N_CH];
  rsh_pkg::lhs_t                      even_sum, odd_sum, lhs;
  rsh_pkg::cmp_t                      rhs;
  logic                               hit;

  // enable chain: a stage moves when it is empty or the next one moves
  always_comb begin
    en[rsh_pkg::N_STG] = !vld[rsh_pkg::N_STG] | result.ready;
    for (int k = rsh_pkg::N_STG - 1; k >= 1; k--) begin
      en[k] = !vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= query.valid;
      for (int k = 2; k <= rsh_pkg::N_STG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign query.ready  = en[1];
  assign result.valid = vld[rsh_pkg::N_STG];
  assign result.hit   = hit;

  // stages 1 to 3
  assign q = '{
    origin_x: query.origin_x, origin_y: query.origin_y, origin_z: query.origin_z,
    dir_x:    query.dir_x,    dir_y:    query.dir_y,    dir_z:    query.dir_z,
    center_x: query.center_x, center_y: query.center_y, center_z: query.center_z,
    radius:   query.radius
  };
  assign fen = '{s1: en[1], s2: en[2], s3: en[3]};

  rsh_front u_front (
    .clk (clk),
    .en  (fen),
    .q   (q),
    .f   (f)
  );

  // stage 4: sign decisions and partial products of t^2
  always_comb begin
    tu              = f.dot[rsh_pkg::TU_W-1:0];
    th              = tu[rsh_pkg::TU_W-1:rsh_pkg::TH_W];
    tl              = tu[rsh_pkg::TH_W-1:0];
    side_c.enclosed = f.diff[rsh_pkg::SQ_W-1] | (f.diff == '0);
    side_c.cand     = !side_c.enclosed && !f.dot[rsh_pkg::DOT_W-1]
                      && !f.k[rsh_pkg::K_W-1] && (f.k != '0);
    side_c.dmag     = f.diff[rsh_pkg::DMAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hh    <= (2*rsh_pkg::TT_W)'(th) * (2*rsh_pkg::TT_W)'(th);
      hl    <= (rsh_pkg::TT_W+rsh_pkg::TH_W)'(th) * (rsh_pkg::TT_W+rsh_pkg::TH_W)'(tl);
      ll    <= (2*rsh_pkg::TH_W)'(tl) * (2*rsh_pkg::TH_W)'(tl);
      kmag4 <= f.k[rsh_pkg::KMAG_W-1:0];
      s4    <= side_c;
    end
  end

  // stage 5: assemble t^2
  always_ff @(posedge clk) begin
    if (en[5]) begin
      tsq   <= (rsh_pkg::tsq_t'(hh) << (2 * rsh_pkg::TH_W))
             + (rsh_pkg::tsq_t'(hl) << (rsh_pkg::TH_W + 1))
             + rsh_pkg::tsq_t'(ll);
      kmag5 <= kmag4;
      s5    <= s4;
    end
  end

  // stage 6: t^2 times k, one chunk per multiplier
  assign tsq_pad = rsh_pkg::pad_t'(tsq);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < rsh_pkg::N_CH; i++) begin
        prod[i] <= rsh_pkg::chprod_t'(tsq_pad[i*rsh_pkg::CH_W +: rsh_pkg::CH_W])
                 * rsh_pkg::chprod_t'(kmag5);
      end
      s6 <= s5;
    end
  end

  // stage 7: even and odd chunk products do not overlap, one add joins them
  always_comb begin
    even_sum = '0;
    odd_sum  = '0;
    for (int i = 0; i < rsh_pkg::N_CH; i++) begin
      if ((i % 2) == 0) begin
        even_sum[i*rsh_pkg::CH_W +: 2*rsh_pkg::CH_W] = prod[i];
      end else begin
        odd_sum[i*rsh_pkg::CH_W +: 2*rsh_pkg::CH_W] = prod[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      lhs <= even_sum + odd_sum;
      s7  <= s6;
    end
  end

  // stage 8: final compare into the output register
  assign rhs = rsh_pkg::cmp_t'(s7.dmag) << (4 * rsh_pkg::DIR_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      hit <= s7.enclosed | (s7.cand & (rsh_pkg::cmp_t'(lhs) > rhs));
    end
  end

  // a full pipeline with a stalled result side takes no query
  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    ((vld == '1) && !result.ready) |-> !query.ready)
    else $error("query taken while every stage is full and stalled");

  // an origin inside or on the sphere always reports a hit
  a_inside_hit : assert property (@(posedge clk) disable iff (rst)
    (vld[rsh_pkg::N_STG-1] && en[rsh_pkg::N_STG] && s7.enclosed) |=> result.hit)
    else $error("origin inside sphere but no hit reported");

  // reset empties the pipeline
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result word valid right after reset");

endmodule
